[rtl/pvd_pkg.sv]
// Shared types, constants and header decode for the prefix varint decoder.
`default_nettype none

package pvd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned ValueW  = 64;
    localparam int unsigned LenW    = 4;
    localparam int unsigned OffsW   = 6;   // payload bit offset, max 56 while in flight
    localparam int unsigned AvailW  = 3;   // header payload bits, 0..7

    // Header prefix masks, one per prefix width of one to eight bits.
    localparam logic [ByteW-1:0] PfxMask1 = 8'h80;
    localparam logic [ByteW-1:0] PfxMask2 = 8'hC0;
    localparam logic [ByteW-1:0] PfxMask3 = 8'hE0;
    localparam logic [ByteW-1:0] PfxMask4 = 8'hF0;
    localparam logic [ByteW-1:0] PfxMask5 = 8'hF8;
    localparam logic [ByteW-1:0] PfxMask6 = 8'hFC;
    localparam logic [ByteW-1:0] PfxMask7 = 8'hFE;
    localparam logic [ByteW-1:0] PfxMask8 = 8'hFF;

    typedef struct packed {
        logic [LenW-1:0]   len;       // code length in bytes, 1..9
        logic [AvailW-1:0] avail;     // payload bits carried by the header
        logic [ByteW-1:0]  pay_mask;  // keeps the header payload bits
        logic [OffsW-1:0]  sign_pos;  // top payload bit of the code
    } t_hdr;

    typedef struct packed {
        logic [ValueW-1:0] magnitude;
        logic              sign_bit;
        logic [LenW-1:0]   code_length;
    } t_result;

    function automatic t_hdr f_hdr_decode(input logic [ByteW-1:0] b);
        t_hdr h;
        case (b) inside
            8'b0???????: h = '{4'd1, 3'd7, ~PfxMask1, 6'd6};
            8'b10??????: h = '{4'd2, 3'd6, ~PfxMask2, 6'd13};
            8'b110?????: h = '{4'd3, 3'd5, ~PfxMask3, 6'd20};
            8'b1110????: h = '{4'd4, 3'd4, ~PfxMask4, 6'd27};
            8'b11110???: h = '{4'd5, 3'd3, ~PfxMask5, 6'd34};
            8'b111110??: h = '{4'd6, 3'd2, ~PfxMask6, 6'd41};
            8'b1111110?: h = '{4'd7, 3'd1, ~PfxMask7, 6'd48};
            8'b11111110: h = '{4'd8, 3'd0, ~PfxMask8, 6'd55};
            default:     h = '{4'd9, 3'd0, ~PfxMask8, 6'd63};
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

[rtl/pvd_in_if.sv]
// Input byte channel of the prefix varint decoder.
`default_nettype none

interface pvd_in_if;
    logic                        valid;
    logic                        ready;
    logic [pvd_pkg::ByteW-1:0]   data_byte;
    logic                        is_signed;

    modport source (output valid, output data_byte, output is_signed, input ready);
    modport sink   (input valid, input data_byte, input is_signed, output ready);
endinterface

`default_nettype wire

[rtl/pvd_out_if.sv]
// Result channel of the prefix varint decoder.
`default_nettype none

interface pvd_out_if;
    logic                        valid;
    logic                        ready;
    logic [pvd_pkg::ValueW-1:0]  magnitude;
    logic                        sign_bit;
    logic [pvd_pkg::LenW-1:0]    code_length;

    modport source (output valid, output magnitude, output sign_bit, output code_length,
                    input ready);
    modport sink   (input valid, input magnitude, input sign_bit, input code_length,
                    output ready);
endinterface

`default_nettype wire

[rtl/prefix_varint_decoder.sv]
// Top level: prefix varint decoder, one stream byte per transfer, one result per code.
//
//  channel | dir | payload                                  | transfer
//  i_in    | in  | data_byte[7:0], is_signed                | valid & ready
//  o_out   | out | magnitude[63:0], sign_bit, code_length[3:0] | valid & ready
//
// One byte per cycle while the skid entry is empty. A code's result is formed
// from its last byte into the output register, or the skid entry if that is held.
// Per continuation byte, the work is one 64-bit shift-and-OR into the accumulator.
// Output register plus one skid entry: bytes keep flowing while a result waits;
// input ready drops only when both are full.
// i_rst_n (synchronous, active low) drops any partial code; next byte is a header.
`default_nettype none

module prefix_varint_decoder (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pvd_in_if.sink       i_in,
    pvd_out_if.source    o_out
);

    localparam int unsigned ValueW = pvd_pkg::ValueW;
    localparam int unsigned LenW   = pvd_pkg::LenW;
    localparam int unsigned OffsW  = pvd_pkg::OffsW;
    localparam int unsigned ByteW  = pvd_pkg::ByteW;

    // decode state
    logic [LenW-1:0]   r_bytes_left, n_bytes_left;   // zero: next byte is a header
    logic [LenW-1:0]   r_code_bytes, n_code_bytes;
    logic [OffsW-1:0]  r_bit_offset, n_bit_offset;
    logic [OffsW-1:0]  r_sign_pos,   n_sign_pos;
    logic [ValueW-1:0] r_acc,        n_acc;
    logic              r_signed,     n_signed;

    // output register and skid entry
    logic              r_out_valid;
    pvd_pkg::t_result  r_out;
    logic              r_skid_valid;
    pvd_pkg::t_result  r_skid;

    logic              in_xfer;
    logic              out_free;
    logic              res_valid;
    pvd_pkg::t_result  res;
    pvd_pkg::t_hdr     hdr;
    logic              is_hdr;
    logic              sgn;

    assign i_in.ready = !r_skid_valid;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign is_hdr     = (r_bytes_left == '0);
    assign hdr        = pvd_pkg::f_hdr_decode(i_in.data_byte);

    // next decode state and the result of the finishing byte
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_code_bytes = r_code_bytes;
        n_bit_offset = r_bit_offset;
        n_sign_pos   = r_sign_pos;
        n_acc        = r_acc;
        n_signed     = r_signed;
        res_valid    = 1'b0;

        if (in_xfer) begin
            if (is_hdr) begin
                // header: keep the bits below the terminating zero
                n_code_bytes = hdr.len;
                n_bit_offset = OffsW'(hdr.avail);
                n_sign_pos   = hdr.sign_pos;
                n_signed     = i_in.is_signed;
                n_acc        = ValueW'(i_in.data_byte & hdr.pay_mask);
                n_bytes_left = hdr.len - LenW'(1);
                res_valid    = (hdr.len == LenW'(1));
            end else begin
                // continuation: whole byte lands at the running offset
                n_acc        = r_acc | (ValueW'(i_in.data_byte) << r_bit_offset);
                n_bit_offset = r_bit_offset + OffsW'(ByteW);
                n_bytes_left = r_bytes_left - LenW'(1);
                res_valid    = (r_bytes_left == LenW'(1));
            end
        end

        // sign extraction at the code's top payload bit
        sgn             = n_signed && n_acc[n_sign_pos];
        res.magnitude   = n_acc & ~(ValueW'(n_signed) << n_sign_pos);
        res.sign_bit    = sgn;
        res.code_length = n_code_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
        end
        r_code_bytes <= n_code_bytes;
        r_bit_offset <= n_bit_offset;
        r_sign_pos   <= n_sign_pos;
        r_acc        <= n_acc;
        r_signed     <= n_signed;
    end

    // result staging: output register first, skid when it is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!out_free && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.magnitude   = r_out.magnitude;
    assign o_out.sign_bit    = r_out.sign_bit;
    assign o_out.code_length = r_out.code_length;

    // skid is only used behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // countdown never exceeds the longest code
    a_bytes_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= LenW'(8))
        else $error("byte countdown out of range");

    // emitted lengths are 1..9
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.code_length >= LenW'(1) && r_out.code_length <= LenW'(9)))
        else $error("code length out of range");

    // a single-byte header with a free output shows up next cycle
    a_short_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_hdr && !i_in.data_byte[ByteW-1] && out_free && !r_skid_valid)
        |=> (r_out_valid && r_out.code_length == LenW'(1)))
        else $error("one byte code not emitted");

    // sign bit is cleared from the magnitude of a nine byte code
    a_sign_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sign_bit && r_out.code_length == LenW'(9))
        |-> !r_out.magnitude[ValueW-1])
        else $error("sign bit left in magnitude");

endmodule

`default_nettype wire
